FILE: src/mipsx_pkg.sv
// Shared definitions for the MIPS integer subset executor.
// Opcode and funct codes, syscall services, fault codes and the execute result bundle.
// No dependencies.
package mipsx_pkg;

    localparam int MEM_WORDS_DEFAULT = 4096;

    localparam logic [5:0] OP_RTYPE = 6'b000000;
    localparam logic [5:0] OP_J     = 6'b000010;
    localparam logic [5:0] OP_JAL   = 6'b000011;
    localparam logic [5:0] OP_BEQ   = 6'b000100;
    localparam logic [5:0] OP_BNE   = 6'b000101;
    localparam logic [5:0] OP_ADDI  = 6'b001000;
    localparam logic [5:0] OP_SLTI  = 6'b001010;
    localparam logic [5:0] OP_ANDI  = 6'b001100;
    localparam logic [5:0] OP_ORI   = 6'b001101;
    localparam logic [5:0] OP_LUI   = 6'b001111;
    localparam logic [5:0] OP_LW    = 6'b100011;
    localparam logic [5:0] OP_SW    = 6'b101011;

    localparam logic [5:0] FN_SLL     = 6'b000000;
    localparam logic [5:0] FN_SRL     = 6'b000010;
    localparam logic [5:0] FN_JR      = 6'b001000;
    localparam logic [5:0] FN_SYSCALL = 6'b001100;
    localparam logic [5:0] FN_ADD     = 6'b100000;
    localparam logic [5:0] FN_SUB     = 6'b100010;
    localparam logic [5:0] FN_AND     = 6'b100100;
    localparam logic [5:0] FN_OR      = 6'b100101;
    localparam logic [5:0] FN_NOR     = 6'b100111;
    localparam logic [5:0] FN_SLT     = 6'b101010;

    localparam logic [31:0] SYS_PRINT_INT = 32'd1;
    localparam logic [31:0] SYS_READ_INT  = 32'd5;
    localparam logic [31:0] SYS_DUMP      = 32'd0;
    localparam logic [31:0] SYS_EXIT      = 32'd10;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_V0   = 5'd2;
    localparam logic [4:0] REG_A0   = 5'd4;
    localparam logic [4:0] REG_GP   = 5'd28;
    localparam logic [4:0] REG_SP   = 5'd29;
    localparam logic [4:0] REG_RA   = 5'd31;

    localparam logic [31:0] GP_RESET = 32'd4000;
    localparam logic [31:0] SP_RESET = 32'd12000;

    typedef enum logic [1:0] {
        FAULT_OK,
        FAULT_FUNCT,
        FAULT_OPCODE,
        FAULT_SYSCALL
    } fault_t;

    typedef struct packed {
        logic        rf_we;
        logic [4:0]  rf_waddr;
        logic [31:0] rf_wdata;
        logic        load;
        logic [4:0]  load_rt;
        logic        store;
        logic [29:0] mem_word;
        logic [31:0] store_data;
        logic [31:0] npc;
        logic        console_valid;
        logic [31:0] console_value;
        logic        dump;
        logic        halt_set;
        logic        halted;
        fault_t      fault;
    } exec_result_t;

    function automatic logic is_syscall(input logic [31:0] ins);
        return (ins[31:26] == OP_RTYPE) && (ins[5:0] == FN_SYSCALL);
    endfunction

    function automatic logic [31:0] rf_reset_value(input logic [4:0] idx);
        logic [31:0] v;
        v = '0;
        if (idx == REG_GP) begin
            v = GP_RESET;
        end else if (idx == REG_SP) begin
            v = SP_RESET;
        end
        return v;
    endfunction

endpackage

FILE: src/mipsx_exec.sv
// Execute logic for one MIPS word: decode, ALU, branch and jump targets, syscall services.
// Purely combinational; uses mipsx_pkg.
module mipsx_exec (
    input  logic [31:0]                ins,
    input  logic [31:0]                cin,
    input  logic [31:0]                a,
    input  logic [31:0]                b,
    input  logic [31:0]                pc,
    input  logic                       halt_in,
    output mipsx_pkg::exec_result_t    res
);

    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [15:0] imm;
    logic [31:0] sext;
    logic [31:0] zext;
    logic [31:0] pc4;
    logic [31:0] sum_imm;
    logic [31:0] br_target;
    logic [31:0] j_target;
    logic        wr;
    logic [4:0]  wr_idx;
    logic [31:0] wr_val;

    assign op             = ins[31:26];
    assign rt             = ins[20:16];
    assign rd             = ins[15:11];
    assign sh             = ins[10:6];
    assign fn             = ins[5:0];
    assign imm            = ins[15:0];
    assign sext           = {{16{imm[15]}}, imm};
    assign zext           = {16'd0, imm};
    assign pc4            = pc + 32'd4;
    assign sum_imm        = a + sext;
    assign br_target      = pc4 + {sext[29:0], 2'b00};
    assign j_target       = {pc4[31:28], ins[25:0], 2'b00};

    always_comb begin
        res        = '0;
        res.npc    = pc4;
        res.fault  = mipsx_pkg::FAULT_OK;
        res.mem_word   = sum_imm[31:2];
        res.store_data = b;
        res.load_rt    = rt;
        wr     = 1'b0;
        wr_idx = rd;
        wr_val = '0;
        if (halt_in) begin
            res.npc    = pc;
            res.halted = 1'b1;
        end else begin
            if (op == mipsx_pkg::OP_RTYPE) begin
                case (fn)
                    mipsx_pkg::FN_ADD: begin wr = 1'b1; wr_val = a + b; end
                    mipsx_pkg::FN_SUB: begin wr = 1'b1; wr_val = a - b; end
                    mipsx_pkg::FN_AND: begin wr = 1'b1; wr_val = a & b; end
                    mipsx_pkg::FN_OR:  begin wr = 1'b1; wr_val = a | b; end
                    mipsx_pkg::FN_NOR: begin wr = 1'b1; wr_val = ~(a | b); end
                    mipsx_pkg::FN_SLT: begin
                        wr = 1'b1;
                        wr_val = {31'd0, $signed(a) < $signed(b)};
                    end
                    mipsx_pkg::FN_SLL: begin wr = 1'b1; wr_val = b << sh; end
                    mipsx_pkg::FN_SRL: begin wr = 1'b1; wr_val = b >> sh; end
                    mipsx_pkg::FN_JR:  res.npc = a;
                    mipsx_pkg::FN_SYSCALL: begin
                        // The read ports were steered to $v0 and $a0 for this word.
                        if (a == mipsx_pkg::SYS_READ_INT) begin
                            wr     = 1'b1;
                            wr_idx = mipsx_pkg::REG_V0;
                            wr_val = cin;
                        end else if (a == mipsx_pkg::SYS_PRINT_INT) begin
                            res.console_valid = 1'b1;
                            res.console_value = b;
                        end else if (a == mipsx_pkg::SYS_DUMP) begin
                            res.dump = 1'b1;
                        end else if (a == mipsx_pkg::SYS_EXIT) begin
                            res.dump     = 1'b1;
                            res.halt_set = 1'b1;
                        end else begin
                            res.fault = mipsx_pkg::FAULT_SYSCALL;
                        end
                    end
                    default: res.fault = mipsx_pkg::FAULT_FUNCT;
                endcase
            end else begin
                wr_idx = rt;
                case (op)
                    mipsx_pkg::OP_J:   res.npc = j_target;
                    mipsx_pkg::OP_JAL: begin
                        res.npc = j_target;
                        wr      = 1'b1;
                        wr_idx  = mipsx_pkg::REG_RA;
                        wr_val  = pc4;
                    end
                    mipsx_pkg::OP_BEQ: if (a == b) res.npc = br_target;
                    mipsx_pkg::OP_BNE: if (a != b) res.npc = br_target;
                    mipsx_pkg::OP_ADDI: begin wr = 1'b1; wr_val = sum_imm; end
                    mipsx_pkg::OP_SLTI: begin
                        wr = 1'b1;
                        wr_val = {31'd0, $signed(a) < $signed(sext)};
                    end
                    mipsx_pkg::OP_ANDI: begin wr = 1'b1; wr_val = a & zext; end
                    mipsx_pkg::OP_ORI:  begin wr = 1'b1; wr_val = a | zext; end
                    mipsx_pkg::OP_LUI:  begin wr = 1'b1; wr_val = {imm, 16'd0}; end
                    mipsx_pkg::OP_LW:   res.load  = 1'b1;
                    mipsx_pkg::OP_SW:   res.store = 1'b1;
                    default: res.fault = mipsx_pkg::FAULT_OPCODE;
                endcase
            end
            res.halted = res.halt_set;
        end
        res.rf_we    = wr && (wr_idx != mipsx_pkg::REG_ZERO);
        res.rf_waddr = wr_idx;
        res.rf_wdata = wr_val;
    end

endmodule

FILE: src/mips_subset_instruction_executor.sv
// Top level of the MIPS integer subset executor: register file, data memory, PC and handshakes.
// Uses mipsx_pkg and mipsx_exec.
//
// Each input beat on the s_ channel carries one machine word fetched at the current PC and
// the integer that a read-int syscall would take. Each beat produces exactly one result
// beat on the m_ channel: the next fetch address, console output, dump request, halt
// status and a fault code.
// An accepted word is registered in ins_reg and executes once the output register can take
// its result, which is then registered in the m_ registers and presented as the result
// beat. A new word is taken every cycle while the output does not stall, except that a load
// holds the input while it executes and its data memory read completes.
// After reset a clearing pass writes zero to every data memory word, one per cycle, so
// s_ready stays low until the pass is done. MEM_WORDS must be a power of two; addresses
// wrap on the word index.
// When the receiver holds m_ready low, the finished result waits in the output register
// and the word under execution waits with it; s_ready is low while it waits, until the result moves on.
// After a syscall 10 every later word only reports the held PC with halted set.
module mips_subset_instruction_executor #(
    parameter int MEM_WORDS = mipsx_pkg::MEM_WORDS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_instruction,
    input  logic signed [31:0] s_console_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_next_pc,
    output logic               m_console_valid,
    output logic signed [31:0] m_console_value,
    output logic               m_dump_request,
    output logic               m_halted,
    output logic [1:0]         m_fault
);

    localparam int AW = $clog2(MEM_WORDS);

    logic [31:0] rf_mem [32];
    logic [31:0] rf_valid_reg;
    logic [31:0] dmem [MEM_WORDS];

    logic [AW:0]   clr_cnt_reg;
    logic          clr_active;

    logic          e_valid_reg;
    logic [31:0]   ins_reg;
    logic [31:0]   cin_reg;
    logic [4:0]    ra1_reg;
    logic [4:0]    ra2_reg;
    logic [31:0]   a_mem_reg;
    logic [31:0]   b_mem_reg;
    logic          a_vld_reg;
    logic          b_vld_reg;
    logic          a_byp_reg;
    logic          b_byp_reg;
    logic [31:0]   fwd_data_reg;
    logic [31:0]   pc_reg;
    logic          halt_reg;

    logic          w_valid_reg;
    logic [4:0]    w_rt_reg;
    logic [31:0]   ld_data_reg;

    logic          m_valid_reg;
    logic [31:0]   m_next_pc_reg;
    logic          m_console_valid_reg;
    logic [31:0]   m_console_value_reg;
    logic          m_dump_reg;
    logic          m_halted_reg;
    mipsx_pkg::fault_t m_fault_reg;

    logic          s_fire;
    logic          e_go;
    logic [4:0]    ra1;
    logic [4:0]    ra2;
    logic [31:0]   a_val;
    logic [31:0]   b_val;
    logic          rf_we;
    logic [4:0]    rf_waddr;
    logic [31:0]   rf_wdata;
    logic [AW-1:0] mem_idx;
    mipsx_pkg::exec_result_t ex;

    assign clr_active = clr_cnt_reg != (AW + 1)'(MEM_WORDS);
    assign e_go       = e_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !clr_active && (!e_valid_reg || (e_go && !ex.load));
    assign s_fire     = s_valid && s_ready;

    // A syscall reads $v0 and $a0 instead of its rs and rt fields.
    assign ra1 = mipsx_pkg::is_syscall(s_instruction) ? mipsx_pkg::REG_V0
                                                      : s_instruction[25:21];
    assign ra2 = mipsx_pkg::is_syscall(s_instruction) ? mipsx_pkg::REG_A0
                                                      : s_instruction[20:16];

    always_comb begin
        if (w_valid_reg) begin
            rf_we    = w_rt_reg != mipsx_pkg::REG_ZERO;
            rf_waddr = w_rt_reg;
            rf_wdata = ld_data_reg;
        end else begin
            rf_we    = e_go && ex.rf_we;
            rf_waddr = ex.rf_waddr;
            rf_wdata = ex.rf_wdata;
        end
    end

    assign a_val = a_byp_reg ? fwd_data_reg
                 : (a_vld_reg ? a_mem_reg : mipsx_pkg::rf_reset_value(ra1_reg));
    assign b_val = b_byp_reg ? fwd_data_reg
                 : (b_vld_reg ? b_mem_reg : mipsx_pkg::rf_reset_value(ra2_reg));

    mipsx_exec u_exec (
        .ins     (ins_reg),
        .cin     (cin_reg),
        .a       (a_val),
        .b       (b_val),
        .pc      (pc_reg),
        .halt_in (halt_reg),
        .res     (ex)
    );

    assign mem_idx = ex.mem_word[AW-1:0];

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[rf_waddr] <= rf_wdata;
        end
        if (s_fire) begin
            a_mem_reg <= rf_mem[ra1];
            b_mem_reg <= rf_mem[ra2];
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_active) begin
            dmem[clr_cnt_reg[AW-1:0]] <= '0;
        end else if (e_go && ex.store) begin
            dmem[mem_idx] <= ex.store_data;
        end
        if (e_go && ex.load) begin
            ld_data_reg <= dmem[mem_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            ins_reg      <= s_instruction;
            cin_reg      <= s_console_in;
            ra1_reg      <= ra1;
            ra2_reg      <= ra2;
            a_vld_reg    <= rf_valid_reg[ra1];
            b_vld_reg    <= rf_valid_reg[ra2];
            a_byp_reg    <= rf_we && (rf_waddr == ra1);
            b_byp_reg    <= rf_we && (rf_waddr == ra2);
            fwd_data_reg <= rf_wdata;
        end
        if (e_go) begin
            w_rt_reg            <= ex.load_rt;
            m_next_pc_reg       <= ex.npc;
            m_console_valid_reg <= ex.console_valid;
            m_console_value_reg <= ex.console_value;
            m_dump_reg          <= ex.dump;
            m_halted_reg        <= ex.halted;
            m_fault_reg         <= ex.fault;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            rf_valid_reg <= '0;
            e_valid_reg  <= 1'b0;
            w_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            pc_reg       <= '0;
            halt_reg     <= 1'b0;
        end else begin
            if (clr_active) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (rf_we) begin
                rf_valid_reg[rf_waddr] <= 1'b1;
            end
            if (s_fire) begin
                e_valid_reg <= 1'b1;
            end else if (e_go) begin
                e_valid_reg <= 1'b0;
            end
            w_valid_reg <= e_go && ex.load;
            if (e_go) begin
                m_valid_reg <= 1'b1;
                pc_reg      <= ex.npc;
                if (ex.halt_set) begin
                    halt_reg <= 1'b1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_next_pc       = m_next_pc_reg;
    assign m_console_valid = m_console_valid_reg;
    assign m_console_value = m_console_value_reg;
    assign m_dump_request  = m_dump_reg;
    assign m_halted        = m_halted_reg;
    assign m_fault         = m_fault_reg;

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active |-> !s_ready)
        else $error("Input accepted during the data memory clearing pass.");

    a_writeback_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        w_valid_reg |-> !e_valid_reg)
        else $error("Load writeback overlaps an executing word.");

    a_load_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (e_valid_reg && ex.load) |-> !s_ready)
        else $error("Input accepted while a load is still in execute.");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg)
        else $error("Halt flag cleared without reset.");

    a_halted_no_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_halted) |-> (m_fault == mipsx_pkg::FAULT_OK))
        else $error("Halted result beat carries a fault code.");
`endif

endmodule

FILE: tb/tb_mips_subset_instruction_executor.sv
// Testbench for mips_subset_instruction_executor: directed and random instruction streams,
// checked beat by beat against a shadow copy of the PC, register file and data memory.
// Depends on mipsx_pkg and the executor RTL; it reads no files.
module tb_mips_subset_instruction_executor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_WORDS = mipsx_pkg::MEM_WORDS_DEFAULT;
    localparam int RANDOM_WORDS = 1050;
    localparam int STEADY_FROM = 400;
    localparam int STEADY_TO = 650;
    localparam int unsigned CYCLE_LIMIT = 200000;

    localparam logic [4:0] REG_T0 = 5'd8;
    localparam logic [4:0] REG_T1 = 5'd9;
    localparam logic [4:0] REG_T2 = 5'd10;
    localparam logic [4:0] REG_T3 = 5'd11;
    localparam logic [4:0] REG_S0 = 5'd16;
    localparam logic [4:0] REG_S1 = 5'd17;
    localparam logic [5:0] FN_UNUSED = 6'b111111;

    typedef struct packed {
        logic [31:0]       next_pc;
        logic              console_valid;
        logic [31:0]       console_value;
        logic              dump;
        logic              halted;
        mipsx_pkg::fault_t fault;
    } outcome_t;

    class retire_scoreboard;
        logic [31:0] pc;
        logic [31:0] gpr [32];
        logic [31:0] dmem [MEM_WORDS];
        bit          halted;
        outcome_t    outcome_q [$];
        int          errors;

        function new();
            pc = '0;
            foreach (gpr[i]) gpr[i] = '0;
            gpr[mipsx_pkg::REG_GP] = mipsx_pkg::GP_RESET;
            gpr[mipsx_pkg::REG_SP] = mipsx_pkg::SP_RESET;
            foreach (dmem[i]) dmem[i] = '0;
            halted = 1'b0;
            errors = 0;
        endfunction

        function void put(input logic [4:0] idx, input logic [31:0] value);
            if (idx != mipsx_pkg::REG_ZERO) begin
                gpr[idx] = value;
            end
        endfunction

        function void note_word(input logic [31:0] ins, input logic [31:0] cin);
            outcome_t    o;
            logic [5:0]  op;
            logic [5:0]  fn;
            logic [4:0]  rs;
            logic [4:0]  rt;
            logic [4:0]  rd;
            logic [4:0]  sh;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] pc4;
            logic [31:0] simm;
            logic [31:0] uimm;
            logic [31:0] jump_to;
            int unsigned widx;
            o = '0;
            if (halted) begin
                o.next_pc = pc;
                o.halted = 1'b1;
                outcome_q.insert(outcome_q.size(), o);
                return;
            end
            op = ins[31:26];
            rs = ins[25:21];
            rt = ins[20:16];
            rd = ins[15:11];
            sh = ins[10:6];
            fn = ins[5:0];
            a = gpr[rs];
            b = gpr[rt];
            pc4 = pc + 32'd4;
            simm = {{16{ins[15]}}, ins[15:0]};
            uimm = {16'h0000, ins[15:0]};
            jump_to = {pc4[31:28], ins[25:0], 2'b00};
            widx = ((a + simm) >> 2) % MEM_WORDS;
            o.next_pc = pc4;
            o.fault = mipsx_pkg::FAULT_OK;
            if (op == mipsx_pkg::OP_RTYPE) begin
                case (fn)
                    mipsx_pkg::FN_ADD: put(rd, a + b);
                    mipsx_pkg::FN_SUB: put(rd, a - b);
                    mipsx_pkg::FN_AND: put(rd, a & b);
                    mipsx_pkg::FN_OR:  put(rd, a | b);
                    mipsx_pkg::FN_NOR: put(rd, ~(a | b));
                    mipsx_pkg::FN_SLT: put(rd, ($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
                    mipsx_pkg::FN_SLL: put(rd, b << sh);
                    mipsx_pkg::FN_SRL: put(rd, b >> sh);
                    mipsx_pkg::FN_JR:  o.next_pc = a;
                    mipsx_pkg::FN_SYSCALL: begin
                        if (gpr[mipsx_pkg::REG_V0] == mipsx_pkg::SYS_READ_INT) begin
                            put(mipsx_pkg::REG_V0, cin);
                        end else if (gpr[mipsx_pkg::REG_V0] == mipsx_pkg::SYS_PRINT_INT) begin
                            o.console_valid = 1'b1;
                            o.console_value = gpr[mipsx_pkg::REG_A0];
                        end else if (gpr[mipsx_pkg::REG_V0] == mipsx_pkg::SYS_DUMP) begin
                            o.dump = 1'b1;
                        end else if (gpr[mipsx_pkg::REG_V0] == mipsx_pkg::SYS_EXIT) begin
                            o.dump = 1'b1;
                            halted = 1'b1;
                        end else begin
                            o.fault = mipsx_pkg::FAULT_SYSCALL;
                        end
                    end
                    default: o.fault = mipsx_pkg::FAULT_FUNCT;
                endcase
            end else begin
                case (op)
                    mipsx_pkg::OP_J:   o.next_pc = jump_to;
                    mipsx_pkg::OP_JAL: begin
                        o.next_pc = jump_to;
                        put(mipsx_pkg::REG_RA, pc4);
                    end
                    mipsx_pkg::OP_BEQ: if (a == b) o.next_pc = pc4 + (simm << 2);
                    mipsx_pkg::OP_BNE: if (a != b) o.next_pc = pc4 + (simm << 2);
                    mipsx_pkg::OP_ADDI: put(rt, a + simm);
                    mipsx_pkg::OP_SLTI: put(rt, ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0);
                    mipsx_pkg::OP_ANDI: put(rt, a & uimm);
                    mipsx_pkg::OP_ORI:  put(rt, a | uimm);
                    mipsx_pkg::OP_LUI:  put(rt, uimm << 16);
                    mipsx_pkg::OP_LW:   put(rt, dmem[widx]);
                    mipsx_pkg::OP_SW:   dmem[widx] = b;
                    default: o.fault = mipsx_pkg::FAULT_OPCODE;
                endcase
            end
            pc = o.next_pc;
            o.halted = halted;
            outcome_q.insert(outcome_q.size(), o);
        endfunction

        function void compare_field(input string field, input logic [31:0] want,
                                    input logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %h, got %h", field, want, got);
                errors++;
            end
        endfunction

        function void check_outcome(input outcome_t got);
            outcome_t want;
            if (outcome_q.size() == 0) begin
                $error("result beat with no instruction pending, next_pc %h", got.next_pc);
                errors++;
                return;
            end
            want = outcome_q.pop_front();
            compare_field("next_pc", want.next_pc, got.next_pc);
            compare_field("console_valid", 32'(want.console_valid), 32'(got.console_valid));
            compare_field("console_value", want.console_value, got.console_value);
            compare_field("dump_request", 32'(want.dump), 32'(got.dump));
            compare_field("halted", 32'(want.halted), 32'(got.halted));
            compare_field("fault", 32'(want.fault), 32'(got.fault));
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [31:0]        s_instruction = '0;
    logic signed [31:0] s_console_in = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [31:0]        m_next_pc;
    logic               m_console_valid;
    logic signed [31:0] m_console_value;
    logic               m_dump_request;
    logic               m_halted;
    logic [1:0]         m_fault;

    retire_scoreboard board = new();
    int          words_sent = 0;
    bit          steady = 1'b0;
    bit          halt_allowed = 1'b0;
    int unsigned cycle_count = 0;

    mips_subset_instruction_executor #(
        .MEM_WORDS(MEM_WORDS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_instruction(s_instruction),
        .s_console_in(s_console_in),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_next_pc(m_next_pc),
        .m_console_valid(m_console_valid),
        .m_console_value(m_console_value),
        .m_dump_request(m_dump_request),
        .m_halted(m_halted),
        .m_fault(m_fault)
    );

    always #5ns aclk = ~aclk;

    function automatic logic [31:0] rword(input logic [4:0] rs, input logic [4:0] rt,
                                          input logic [4:0] rd, input logic [4:0] sh,
                                          input logic [5:0] fn);
        return {mipsx_pkg::OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] iword(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [15:0] rand_imm();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic [31:0] ins, input logic [31:0] cin);
        if (!halt_allowed && ins[31:26] == mipsx_pkg::OP_RTYPE
            && ins[5:0] == mipsx_pkg::FN_SYSCALL
            && board.gpr[mipsx_pkg::REG_V0] == mipsx_pkg::SYS_EXIT) begin
            ins = iword(mipsx_pkg::OP_ADDI, mipsx_pkg::REG_ZERO, mipsx_pkg::REG_V0,
                        16'(mipsx_pkg::SYS_PRINT_INT));
        end
        while (!steady && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_instruction <= ins;
        s_console_in <= cin;
        do @(posedge aclk); while (!s_ready);
        board.note_word(ins, cin);
        words_sent++;
    endtask

    task automatic send_random_group();
        int unsigned pick;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic [4:0]  rc;
        logic [4:0]  base;
        logic [15:0] imm;
        logic [15:0] code;
        pick = $urandom_range(99);
        ra = 5'($urandom);
        rb = 5'($urandom);
        rc = 5'($urandom);
        imm = rand_imm();
        if (pick < 12) begin
            send_word($urandom, $urandom);
        end else if (pick < 30) begin
            case ($urandom_range(5))
                0: code = 16'(mipsx_pkg::SYS_DUMP);
                1, 2: code = 16'(mipsx_pkg::SYS_PRINT_INT);
                3: code = 16'(mipsx_pkg::SYS_READ_INT);
                4: code = 16'd7;
                default: code = 16'($urandom);
            endcase
            send_word(iword(mipsx_pkg::OP_ADDI, mipsx_pkg::REG_ZERO, mipsx_pkg::REG_V0, code),
                      $urandom);
            if ($urandom_range(1) == 1) begin
                send_word(iword(mipsx_pkg::OP_ADDI, rb, mipsx_pkg::REG_A0, imm), $urandom);
            end
            send_word({mipsx_pkg::OP_RTYPE, 20'($urandom), mipsx_pkg::FN_SYSCALL}, $urandom);
        end else if (pick < 50) begin
            case ($urandom_range(3))
                0: base = mipsx_pkg::REG_ZERO;
                1: base = mipsx_pkg::REG_GP;
                2: base = mipsx_pkg::REG_SP;
                default: base = ra;
            endcase
            if ($urandom_range(3) != 0) begin
                imm = 16'($urandom_range(63) << 2) - 16'd128;
            end
            send_word(iword(mipsx_pkg::OP_SW, base, rb, imm), $urandom);
            if ($urandom_range(3) != 0) begin
                send_word(iword(mipsx_pkg::OP_LW, base, rc, imm), $urandom);
            end
        end else if (pick < 62) begin
            if ($urandom_range(1) == 1) begin
                rb = ra;
            end
            case ($urandom_range(4))
                0: send_word(iword(mipsx_pkg::OP_BEQ, ra, rb, imm), $urandom);
                1: send_word(iword(mipsx_pkg::OP_BNE, ra, rb, imm), $urandom);
                2: send_word({mipsx_pkg::OP_J, 26'($urandom)}, $urandom);
                3: send_word({mipsx_pkg::OP_JAL, 26'($urandom)}, $urandom);
                default: send_word(rword(($urandom_range(1) == 1) ? mipsx_pkg::REG_RA : ra,
                                         mipsx_pkg::REG_ZERO, mipsx_pkg::REG_ZERO, 5'd0,
                                         mipsx_pkg::FN_JR), $urandom);
            endcase
        end else begin
            case ($urandom_range(12))
                0: send_word(rword(ra, rb, rc, 5'd0, mipsx_pkg::FN_ADD), $urandom);
                1: send_word(rword(ra, rb, rc, 5'd0, mipsx_pkg::FN_SUB), $urandom);
                2: send_word(rword(ra, rb, rc, 5'd0, mipsx_pkg::FN_AND), $urandom);
                3: send_word(rword(ra, rb, rc, 5'd0, mipsx_pkg::FN_OR), $urandom);
                4: send_word(rword(ra, rb, rc, 5'd0, mipsx_pkg::FN_NOR), $urandom);
                5: send_word(rword(ra, rb, rc, 5'd0, mipsx_pkg::FN_SLT), $urandom);
                6: send_word(rword(ra, rb, rc, 5'($urandom), mipsx_pkg::FN_SLL), $urandom);
                7: send_word(rword(ra, rb, rc, 5'($urandom), mipsx_pkg::FN_SRL), $urandom);
                8: send_word(iword(mipsx_pkg::OP_ADDI, ra, rb, imm), $urandom);
                9: send_word(iword(mipsx_pkg::OP_SLTI, ra, rb, imm), $urandom);
                10: send_word(iword(mipsx_pkg::OP_ANDI, ra, rb, imm), $urandom);
                11: send_word(iword(mipsx_pkg::OP_ORI, ra, rb, imm), $urandom);
                default: send_word(iword(mipsx_pkg::OP_LUI, ra, rb, imm), $urandom);
            endcase
        end
    endtask

    task automatic run_directed();
        logic [31:0] sys_word;
        sys_word = rword(mipsx_pkg::REG_ZERO, mipsx_pkg::REG_ZERO, mipsx_pkg::REG_ZERO, 5'd0,
                         mipsx_pkg::FN_SYSCALL);
        send_word(sys_word, 32'h0);
        send_word(32'h0000_0000, 32'h8000_0000);
        send_word(iword(mipsx_pkg::OP_LUI, mipsx_pkg::REG_ZERO, REG_T0, 16'hFFFF), 32'h0);
        send_word(iword(mipsx_pkg::OP_ORI, REG_T0, REG_T0, 16'hFFFF), 32'h0);
        send_word(iword(mipsx_pkg::OP_ADDI, mipsx_pkg::REG_ZERO, REG_T1, 16'h8000), 32'h0);
        send_word(rword(REG_T0, REG_T1, REG_T2, 5'd0, mipsx_pkg::FN_ADD), 32'h0);
        send_word(rword(REG_T1, REG_T0, REG_T3, 5'd0, mipsx_pkg::FN_SUB), 32'h0);
        send_word(rword(REG_T0, REG_T1, REG_T2, 5'd0, mipsx_pkg::FN_AND), 32'h0);
        send_word(rword(REG_T0, REG_T1, REG_T3, 5'd0, mipsx_pkg::FN_OR), 32'h0);
        send_word(rword(REG_T1, mipsx_pkg::REG_ZERO, REG_T2, 5'd0, mipsx_pkg::FN_NOR), 32'h0);
        send_word(rword(REG_T1, REG_T0, REG_T3, 5'd0, mipsx_pkg::FN_SLT), 32'h0);
        send_word(iword(mipsx_pkg::OP_SLTI, REG_T0, REG_S0, 16'h0001), 32'h0);
        send_word(iword(mipsx_pkg::OP_ANDI, REG_T0, REG_S1, 16'h8001), 32'h0);
        send_word(rword(mipsx_pkg::REG_ZERO, REG_T0, REG_T2, 5'd31, mipsx_pkg::FN_SLL), 32'h0);
        send_word(rword(mipsx_pkg::REG_ZERO, REG_T0, REG_T3, 5'd31, mipsx_pkg::FN_SRL), 32'h0);
        send_word(iword(mipsx_pkg::OP_SW, mipsx_pkg::REG_GP, REG_T0, 16'hFFFC), 32'h0);
        send_word(iword(mipsx_pkg::OP_LW, mipsx_pkg::REG_GP, REG_S0, 16'hFFFC), 32'h0);
        send_word(iword(mipsx_pkg::OP_ADDI, REG_T0, mipsx_pkg::REG_ZERO, 16'h7FFF), 32'h0);
        send_word(iword(mipsx_pkg::OP_SW, mipsx_pkg::REG_GP, mipsx_pkg::REG_ZERO, 16'hFFFC),
                  32'h0);
        send_word(iword(mipsx_pkg::OP_BEQ, mipsx_pkg::REG_ZERO, mipsx_pkg::REG_ZERO, 16'hFFFF),
                  32'h0);
        send_word(iword(mipsx_pkg::OP_BNE, REG_T0, mipsx_pkg::REG_ZERO, 16'h7FFF), 32'h0);
        send_word({mipsx_pkg::OP_JAL, 26'h3FF_FFFF}, 32'h0);
        send_word(rword(mipsx_pkg::REG_RA, mipsx_pkg::REG_ZERO, mipsx_pkg::REG_ZERO, 5'd0,
                        mipsx_pkg::FN_JR), 32'h0);
        send_word(rword(mipsx_pkg::REG_ZERO, mipsx_pkg::REG_ZERO, mipsx_pkg::REG_ZERO, 5'd0,
                        FN_UNUSED), 32'h0);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(iword(mipsx_pkg::OP_ADDI, mipsx_pkg::REG_ZERO, mipsx_pkg::REG_V0,
                        16'(mipsx_pkg::SYS_READ_INT)), 32'h0);
        send_word(sys_word, 32'h7FFF_FFFF);
        send_word(sys_word, 32'h0);
        send_word(iword(mipsx_pkg::OP_ADDI, mipsx_pkg::REG_ZERO, mipsx_pkg::REG_V0,
                        16'(mipsx_pkg::SYS_PRINT_INT)), 32'h0);
        send_word(sys_word, 32'h0);
    endtask

    always @(posedge aclk) begin : watch_results
        outcome_t got;
        if (aresetn && m_valid && m_ready) begin
            got.next_pc = m_next_pc;
            got.console_valid = m_console_valid;
            got.console_value = m_console_value;
            got.dump = m_dump_request;
            got.halted = m_halted;
            got.fault = mipsx_pkg::fault_t'(m_fault);
            board.check_outcome(got);
        end
        m_ready <= steady || ($urandom_range(99) >= 8);
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int random_start;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS) begin
            steady = (words_sent - random_start >= STEADY_FROM)
                && (words_sent - random_start < STEADY_TO);
            send_random_group();
        end
        steady = 1'b0;
        // Halt last, then confirm that later words only report the held PC with halted set.
        halt_allowed = 1'b1;
        send_word(iword(mipsx_pkg::OP_ADDI, mipsx_pkg::REG_ZERO, mipsx_pkg::REG_V0,
                        16'(mipsx_pkg::SYS_EXIT)), $urandom);
        send_word(rword(mipsx_pkg::REG_ZERO, mipsx_pkg::REG_ZERO, mipsx_pkg::REG_ZERO, 5'd0,
                        mipsx_pkg::FN_SYSCALL), $urandom);
        send_word(iword(mipsx_pkg::OP_LW, mipsx_pkg::REG_GP, REG_T0, 16'h0000), $urandom);
        repeat (4) send_word($urandom, $urandom);
        s_valid <= 1'b0;
        while (board.outcome_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (board.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/mipsx_pkg.sv
src/mipsx_exec.sv
src/mips_subset_instruction_executor.sv
tb/tb_mips_subset_instruction_executor.sv
